### sv/ipv4p_pkg.sv
// Package for the IPv4 dotted text parser: parse phase and radix codes,
// part-width limits. No dependencies.
package ipv4p_pkg;

    // Parse phase of the current part
    typedef enum logic [2:0] {
        PH_START  = 3'd0,   // expect the first digit of a part
        PH_ZERO   = 3'd1,   // just after a leading zero
        PH_DIGITS = 3'd2,   // inside the digits of a part
        PH_TAIL   = 3'd3    // whitespace seen, rest of the text ignored
    } phase_t;

    // Radix of the current part
    typedef enum logic [1:0] {
        RX_DEC = 2'd0,
        RX_OCT = 2'd1,
        RX_HEX = 2'd2
    } radix_t;

    localparam int unsigned PART_DEPTH = 3;
    localparam logic [31:0] LIMIT_24 = 32'h00ff_ffff;
    localparam logic [31:0] LIMIT_16 = 32'h0000_ffff;
    localparam logic [31:0] LIMIT_8  = 32'h0000_00ff;

    localparam logic [7:0] CH_END = 8'h00;
    localparam logic [7:0] CH_DOT = 8'h2e;

endpackage

### sv/ipv4_dotted_text_parser_core.sv
// IPv4 dotted text parser core: input byte stage, parse state, result register.
// Depends on ipv4p_pkg.
//
// Takes address text one byte per transfer on ch, ended by a zero byte, and
// delivers one result per string at the zero byte: valid_res and the 32-bit
// address (first part in bits 31..24, zero when invalid). One to four dotted
// parts are accepted, each decimal, octal (leading 0) or hex (0x/0X); the last
// part fills the remaining bits. Whitespace after a part ends the parse with
// success and later bytes are ignored; octal digits 8 or 9, earlier parts
// above 255, a fifth part, a part above 32 bits or a last part too wide reject.
// Throughput is one byte per cycle unless the input stalls: each byte is held
// in the input stage, then a single shift-add of the accumulator updates the
// parse state. A result is loaded into the result register at the edge on which
// its zero byte leaves the input stage, and can be taken from the next edge on.
// Input stalls only when a zero byte is held while the previous result still
// waits to be taken.
module ipv4_dotted_text_parser_core (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [7:0]  ch,
    output logic        out_valid,
    input  logic        out_ready,
    output logic        valid_res,
    output logic [31:0] address
);

    // Input stage
    logic [7:0] ch_reg;
    logic       ch_vld_reg;

    // Parse state
    ipv4p_pkg::phase_t phase_reg, phase_next;
    ipv4p_pkg::radix_t radix_reg, radix_next;
    logic [31:0] accum_reg, accum_next;
    logic        overflowed_reg, overflowed_next;
    logic [7:0]  part_store_reg [ipv4p_pkg::PART_DEPTH];
    logic [7:0]  part_store_next [ipv4p_pkg::PART_DEPTH];
    logic [1:0]  part_count_reg, part_count_next;
    logic        rejected_reg, rejected_next;

    // Result register
    logic        out_vld_reg;
    logic        valid_res_reg, valid_res_next;
    logic [31:0] address_reg, address_next;

    // Decode
    logic        ch_is_end;
    logic        advance;
    logic        active;
    logic        is_dec;
    logic        is_lc_hex;
    logic        is_uc_hex;
    logic        is_x;
    logic        is_space;
    logic        is_dot;
    ipv4p_pkg::radix_t eff_radix;
    logic        oct_bad;
    logic        is_digit;
    logic [3:0]  dval;
    logic [35:0] product;
    logic [35:0] sum;
    logic        sum_ovf;
    logic        dot_bad;
    logic        finish_ok;
    logic [31:0] finish_addr;

    // Handshake: the stage moves on unless a zero byte meets a waiting result
    assign ch_is_end = (ch_reg == ipv4p_pkg::CH_END);
    assign advance   = ch_vld_reg && (!ch_is_end || !out_vld_reg || out_ready);
    assign in_ready  = !ch_vld_reg || advance;
    assign active    = advance && !ch_is_end && !rejected_reg
                       && (phase_reg != ipv4p_pkg::PH_TAIL);

    // Classify the held byte
    always_comb
    begin
        is_dec    = (ch_reg >= 8'h30) && (ch_reg <= 8'h39);
        is_lc_hex = (ch_reg >= 8'h61) && (ch_reg <= 8'h66);
        is_uc_hex = (ch_reg >= 8'h41) && (ch_reg <= 8'h46);
        is_x      = (ch_reg == 8'h78) || (ch_reg == 8'h58);
        is_space  = (ch_reg == 8'h20) || ((ch_reg >= 8'h09) && (ch_reg <= 8'h0d));
        is_dot    = (ch_reg == ipv4p_pkg::CH_DOT);
        eff_radix = (phase_reg == ipv4p_pkg::PH_ZERO) ? ipv4p_pkg::RX_OCT : radix_reg;
        oct_bad   = is_dec && (eff_radix == ipv4p_pkg::RX_OCT) && (ch_reg >= 8'h38);
        is_digit  = (is_dec && !oct_bad)
                    || ((eff_radix == ipv4p_pkg::RX_HEX) && (is_lc_hex || is_uc_hex));
        if (is_dec)
            dval = 4'(ch_reg - 8'h30);
        else if (is_lc_hex)
            dval = 4'(ch_reg - 8'h57);
        else
            dval = 4'(ch_reg - 8'h37);
    end

    // Shift-add of the accumulator in the current radix
    always_comb
    begin
        case (eff_radix)
            ipv4p_pkg::RX_OCT: product = {1'b0, accum_reg, 3'b000};
            ipv4p_pkg::RX_HEX: product = {accum_reg, 4'b0000};
            default:           product = {1'b0, accum_reg, 3'b000}
                                         + {3'b000, accum_reg, 1'b0};
        endcase
        sum     = product + {32'd0, dval};
        sum_ovf = (sum[35:32] != 4'd0);
        dot_bad = (part_count_reg == 2'd3) || (accum_reg > ipv4p_pkg::LIMIT_8);
    end

    // Result for the end of the string
    always_comb
    begin
        finish_ok   = !rejected_reg && !overflowed_reg
                      && (phase_reg != ipv4p_pkg::PH_START);
        finish_addr = accum_reg;
        case (part_count_reg)
            2'd1:
            begin
                finish_ok   = finish_ok && (accum_reg <= ipv4p_pkg::LIMIT_24);
                finish_addr = accum_reg | {part_store_reg[0], 24'd0};
            end
            2'd2:
            begin
                finish_ok   = finish_ok && (accum_reg <= ipv4p_pkg::LIMIT_16);
                finish_addr = accum_reg | {part_store_reg[0], part_store_reg[1], 16'd0};
            end
            2'd3:
            begin
                finish_ok   = finish_ok && (accum_reg <= ipv4p_pkg::LIMIT_8);
                finish_addr = accum_reg
                              | {part_store_reg[0], part_store_reg[1], part_store_reg[2], 8'd0};
            end
            default:
            begin
                finish_ok   = finish_ok;
                finish_addr = accum_reg;
            end
        endcase
        valid_res_next = finish_ok;
        address_next   = finish_ok ? finish_addr : 32'd0;
    end

    // Next parse phase
    always_comb
    begin
        phase_next = phase_reg;
        if (advance && ch_is_end)
            phase_next = ipv4p_pkg::PH_START;
        else if (active)
        begin
            case (phase_reg)
                ipv4p_pkg::PH_START:
                begin
                    if (is_dec)
                        phase_next = (ch_reg == 8'h30) ? ipv4p_pkg::PH_ZERO
                                                       : ipv4p_pkg::PH_DIGITS;
                end
                ipv4p_pkg::PH_ZERO, ipv4p_pkg::PH_DIGITS:
                begin
                    if (phase_reg == ipv4p_pkg::PH_ZERO && is_x)
                        phase_next = ipv4p_pkg::PH_DIGITS;
                    else if (!oct_bad && !is_digit && is_dot && !dot_bad)
                        phase_next = ipv4p_pkg::PH_START;
                    else if (!oct_bad && !is_digit && !is_dot && is_space)
                        phase_next = ipv4p_pkg::PH_TAIL;
                    else
                        phase_next = ipv4p_pkg::PH_DIGITS;
                end
                default: phase_next = phase_reg;
            endcase
        end
    end

    // Next datapath state
    always_comb
    begin
        radix_next      = radix_reg;
        accum_next      = accum_reg;
        overflowed_next = overflowed_reg;
        part_store_next = part_store_reg;
        part_count_next = part_count_reg;
        rejected_next   = rejected_reg;
        if (advance && ch_is_end)
        begin
            radix_next      = ipv4p_pkg::RX_DEC;
            accum_next      = 32'd0;
            overflowed_next = 1'b0;
            for (int i = 0; i < ipv4p_pkg::PART_DEPTH; i++)
                part_store_next[i] = 8'd0;
            part_count_next = 2'd0;
            rejected_next   = 1'b0;
        end
        else if (active)
        begin
            case (phase_reg)
                ipv4p_pkg::PH_START:
                begin
                    if (!is_dec)
                        rejected_next = 1'b1;
                    else
                    begin
                        radix_next = (ch_reg == 8'h30) ? radix_reg : ipv4p_pkg::RX_DEC;
                        accum_next = {28'd0, dval};
                    end
                end
                ipv4p_pkg::PH_ZERO, ipv4p_pkg::PH_DIGITS:
                begin
                    if (phase_reg == ipv4p_pkg::PH_ZERO && is_x)
                        radix_next = ipv4p_pkg::RX_HEX;
                    else
                    begin
                        radix_next = eff_radix;
                        if (oct_bad)
                            rejected_next = 1'b1;
                        else if (is_digit)
                        begin
                            if (sum_ovf)
                            begin
                                overflowed_next = 1'b1;
                                rejected_next   = 1'b1;
                            end
                            else
                                accum_next = sum[31:0];
                        end
                        else if (is_dot)
                        begin
                            if (dot_bad)
                                rejected_next = 1'b1;
                            else
                            begin
                                part_store_next[part_count_reg] = accum_reg[7:0];
                                part_count_next = part_count_reg + 2'd1;
                                accum_next      = 32'd0;
                                radix_next      = ipv4p_pkg::RX_DEC;
                            end
                        end
                        else if (!is_space)
                            rejected_next = 1'b1;
                    end
                end
                default: rejected_next = rejected_reg;
            endcase
        end
    end

    // Input stage: hold a byte until it advances
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            ch_vld_reg <= 1'b0;
        else if (in_ready)
            ch_vld_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
            ch_reg <= ch;
    end

    // Parse state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg      <= ipv4p_pkg::PH_START;
            radix_reg      <= ipv4p_pkg::RX_DEC;
            accum_reg      <= 32'd0;
            overflowed_reg <= 1'b0;
            for (int i = 0; i < ipv4p_pkg::PART_DEPTH; i++)
                part_store_reg[i] <= 8'd0;
            part_count_reg <= 2'd0;
            rejected_reg   <= 1'b0;
        end
        else
        begin
            phase_reg      <= phase_next;
            radix_reg      <= radix_next;
            accum_reg      <= accum_next;
            overflowed_reg <= overflowed_next;
            part_store_reg <= part_store_next;
            part_count_reg <= part_count_next;
            rejected_reg   <= rejected_next;
        end
    end

    // Result register: load at the end byte, drop on transfer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_vld_reg <= 1'b0;
        else if (advance && ch_is_end)
            out_vld_reg <= 1'b1;
        else if (out_ready)
            out_vld_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (advance && ch_is_end)
        begin
            valid_res_reg <= valid_res_next;
            address_reg   <= address_next;
        end
    end

    assign out_valid = out_vld_reg;
    assign valid_res = valid_res_reg;
    assign address   = address_reg;

`ifndef SYNTHESIS
    // An invalid result carries a zero address
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !valid_res |-> address == 32'd0)
        else $error("invalid result with nonzero address");

    // The end byte leaves the parse state cleared
    assert property (@(posedge clk) disable iff (!rst_n)
        advance && ch_is_end |=> phase_reg == ipv4p_pkg::PH_START
            && part_count_reg == 2'd0 && !rejected_reg && accum_reg == 32'd0)
        else $error("parse state not cleared after end byte");

    // Overflow always marks the string as rejected
    assert property (@(posedge clk) disable iff (!rst_n)
        overflowed_reg |-> rejected_reg)
        else $error("overflow without reject");

    // The input stage stalls only for an end byte behind a waiting result
    assert property (@(posedge clk) disable iff (!rst_n)
        ch_vld_reg && !advance |-> ch_is_end && out_vld_reg && !out_ready)
        else $error("input stage stalled without cause");

    // Whitespace tail is reached only on a string not rejected
    assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg == ipv4p_pkg::PH_TAIL |-> !rejected_reg)
        else $error("rejected string in whitespace tail");
`endif

endmodule
